// ===== rtl/cea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cea_pkg;

   // Port field widths
   localparam int LEN_W   = 13;
   localparam int START_W = 12;
   localparam int COUNT_W = 13;

   // Block map is kept in words of this many blocks
   localparam int WORD_W   = 32;
   localparam int WORD_LOG = 5;

   localparam logic [COUNT_W-1:0] CFG_RESET = 13'd4096;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NOSPACE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/cea_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cea_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/contiguous_extent_allocator_top.sv =====
// First-fit allocator of contiguous block runs. The block map lives in one RAM of
// 32-block words; after reset a clearing sweep writes every word to zero, one word a
// cycle (128 words at the default MAX_BLOCKS of 4096), with busy high. A request is
// taken when start is high and busy is low. A zero length, or one above the active
// limit min(blocks_in_use, MAX_BLOCKS), is answered on the next cycle with no-space.
// Otherwise the block reads the map one word per cycle from block 0 upward. busy then
// stays high while it reads words up to the word where the run ends (or up to the
// last word under the limit on no-space), forms the run, and then marks each word the
// run covers with a read-modify-write. busy drops as the result strobe rises. Each
// result is shown on the rsp_ ports for exactly one cycle with rsp_valid high and
// cannot be held off by the receiver. The blocks_in_use register may be written at
// any time the block is idle; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_extent_allocator_top #(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [cea_pkg::LEN_W-1:0]   req_run_length,
   output logic                             rsp_valid,
   output logic                             rsp_status,
   output logic      [cea_pkg::START_W-1:0] rsp_first_block,
   output logic      [cea_pkg::COUNT_W-1:0] rsp_free_blocks,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [cea_pkg::COUNT_W-1:0] csr_blocks_in_use
);

   localparam int WORD_W    = cea_pkg::WORD_W;
   localparam int WORD_LOG  = cea_pkg::WORD_LOG;
   localparam int CNT_MAX   = (1 << cea_pkg::COUNT_W) - 1;
   localparam int MAX_LIMIT = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
   localparam int BW        = $clog2(MAX_LIMIT + 1);
   localparam int WIW       = BW - WORD_LOG;
   localparam int NW        = (MAX_LIMIT + WORD_W - 1) / WORD_W;
   localparam int AW        = $clog2(NW);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FOUND,
      ST_MARK
   } state_type;

   // control registers
   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]               alloc_ff, alloc_in;
   logic [cea_pkg::COUNT_W-1:0] csr_ff, csr_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic                        sc_issue_ff, sc_issue_in;
   logic                        dv_ff, dv_in;
   logic                        mk_issue_ff, mk_issue_in;
   logic                        pend_ff, pend_in;

   // payload registers
   logic                        rsp_status_ff, rsp_status_in;
   logic [cea_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [cea_pkg::COUNT_W-1:0] rsp_free_ff, rsp_free_in;
   logic [BW-1:0]               len_ff, len_in;
   logic [BW-1:0]               rem_ff, rem_in;
   logic [WIW-1:0]              rd_word_ff, rd_word_in;
   logic [WIW-1:0]              proc_word_ff, proc_word_in;
   logic [WIW-1:0]              hit_word_ff, hit_word_in;
   logic [WORD_LOG-1:0]         hit_j_ff, hit_j_in;
   logic [BW-1:0]               start_ff, start_in;
   logic [BW-1:0]               end_ff, end_in;
   logic [WIW-1:0]              mk_rd_ff, mk_rd_in;
   logic [WIW-1:0]              pend_word_ff, pend_word_in;

   // RAM port
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   // limit and counts
   logic [BW-1:0]  lim, lim_m1;
   logic [WIW-1:0] last_word;
   logic           req_ok;
   logic [BW-1:0]  alloc_sum, free_cur, free_new;

   // word scan
   logic [BW-1:0]       base, vc;
   logic                last_in_word;
   logic [WORD_W-1:0]   valid_mask, fv, rem_mask;
   logic                pre_hit, in_hit, all_free;
   logic [WORD_LOG-1:0] pre_j, in_j, hi_used, tz;
   logic [WORD_W-1:0]   win_p [WORD_LOG+1];
   logic [WORD_W-1:0]   win_h;
   logic                win_seen;
   logic [BW-1:0]       rem_next;

   // run marking
   logic [BW-1:0]       run_end, run_start;
   logic [WIW-1:0]      start_word, end_word;
   logic [WORD_LOG-1:0] mk_lo, mk_hi;
   logic [WORD_W-1:0]   mk_mask;

   cea_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NW)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign lim = (csr_ff > cea_pkg::COUNT_W'(MAX_LIMIT)) ? BW'(MAX_LIMIT) : BW'(csr_ff);
   assign lim_m1    = lim - BW'(1);
   assign last_word = lim_m1[BW-1:WORD_LOG];
   assign req_ok    = (req_run_length != '0) &&
                      (req_run_length <= cea_pkg::LEN_W'(lim));
   assign alloc_sum = alloc_ff + len_ff;
   assign free_cur  = (lim > alloc_ff)  ? lim - alloc_ff  : '0;
   assign free_new  = (lim > alloc_sum) ? lim - alloc_sum : '0;

   // Evaluate one map word against the run being searched for
   always_comb begin
      base         = {proc_word_ff, {WORD_LOG{1'b0}}};
      vc           = lim - base;
      last_in_word = (vc <= BW'(WORD_W));
      valid_mask   = (vc >= BW'(WORD_W)) ? '1 : ~({WORD_W{1'b1}} << vc[WORD_LOG-1:0]);
      // blocks past the limit count as used
      fv           = ~ram_rdata & valid_mask;
      all_free     = &fv;

      // run carried in from earlier words finishes inside this word
      rem_mask = (rem_ff >= BW'(WORD_W)) ? '1 : ~({WORD_W{1'b1}} << rem_ff[WORD_LOG-1:0]);
      pre_hit  = (rem_ff <= BW'(WORD_W)) && ((fv & rem_mask) == rem_mask);
      pre_j    = rem_ff[WORD_LOG-1:0] - WORD_LOG'(1);

      // win_p[k][j]: 2**k free blocks end at bit j
      win_p[0] = fv;
      for (int k = 1; k <= WORD_LOG; k++) begin
         win_p[k] = win_p[k-1] & (win_p[k-1] << (1 << (k-1)));
      end
      // chain segments by the bits of the length
      win_h    = '0;
      win_seen = 1'b0;
      for (int k = 0; k <= WORD_LOG; k++) begin
         if (len_ff[k]) begin
            win_h    = win_seen ? (win_p[k] & (win_h << (1 << k))) : win_p[k];
            win_seen = 1'b1;
         end
      end
      in_hit = (len_ff <= BW'(WORD_W)) && (|win_h);
      in_j   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (win_h[i]) begin
            in_j = WORD_LOG'(i);
         end
      end

      // free blocks at the top of the word carry into the next one
      hi_used = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (!fv[i]) begin
            hi_used = WORD_LOG'(i);
         end
      end
      tz       = WORD_LOG'(WORD_W - 1) - hi_used;
      rem_next = all_free ? rem_ff - BW'(WORD_W) : len_ff - BW'(tz);
   end

   // Mask of run bits inside the word being marked
   always_comb begin
      run_end    = {hit_word_ff, hit_j_ff};
      run_start  = run_end + BW'(1) - len_ff;
      start_word = start_ff[BW-1:WORD_LOG];
      end_word   = end_ff[BW-1:WORD_LOG];
      mk_lo      = (pend_word_ff == start_word) ? start_ff[WORD_LOG-1:0] : '0;
      mk_hi      = (pend_word_ff == end_word) ? end_ff[WORD_LOG-1:0] : '1;
      mk_mask    = ({WORD_W{1'b1}} << mk_lo) &
                   ({WORD_W{1'b1}} >> (WORD_LOG'(WORD_W - 1) - mk_hi));
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         ST_SCAN: begin
            ram_re    = sc_issue_ff;
            ram_raddr = AW'(rd_word_ff);
         end
         ST_MARK: begin
            ram_re    = mk_issue_ff;
            ram_raddr = AW'(mk_rd_ff);
            ram_we    = pend_ff;
            ram_waddr = AW'(pend_word_ff);
            ram_wdata = ram_rdata | mk_mask;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      alloc_in      = alloc_ff;
      csr_in        = csr_valid ? csr_blocks_in_use : csr_ff;
      clr_in        = clr_ff;
      sc_issue_in   = sc_issue_ff;
      dv_in         = 1'b0;
      mk_issue_in   = mk_issue_ff;
      pend_in       = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;
      len_in        = len_ff;
      rem_in        = rem_ff;
      rd_word_in    = rd_word_ff;
      proc_word_in  = proc_word_ff;
      hit_word_in   = hit_word_ff;
      hit_j_in      = hit_j_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      mk_rd_in      = mk_rd_ff;
      pend_word_in  = pend_word_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_ok) begin
                  len_in      = BW'(req_run_length);
                  rem_in      = BW'(req_run_length);
                  rd_word_in  = '0;
                  sc_issue_in = 1'b1;
                  state_in    = ST_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = cea_pkg::STATUS_NOSPACE;
                  rsp_start_in  = '0;
                  rsp_free_in   = cea_pkg::COUNT_W'(free_cur);
               end
            end
         end
         ST_SCAN: begin
            // keep reads one word ahead of the evaluation
            dv_in        = sc_issue_ff;
            proc_word_in = rd_word_ff;
            if (sc_issue_ff) begin
               if (rd_word_ff == last_word) begin
                  sc_issue_in = 1'b0;
               end else begin
                  rd_word_in = rd_word_ff + WIW'(1);
               end
            end
            if (dv_ff) begin
               if (pre_hit || in_hit) begin
                  hit_word_in = proc_word_ff;
                  hit_j_in    = pre_hit ? pre_j : in_j;
                  sc_issue_in = 1'b0;
                  state_in    = ST_FOUND;
               end else if (last_in_word) begin
                  sc_issue_in   = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = cea_pkg::STATUS_NOSPACE;
                  rsp_start_in  = '0;
                  rsp_free_in   = cea_pkg::COUNT_W'(free_cur);
                  state_in      = ST_IDLE;
               end else begin
                  rem_in = rem_next;
               end
            end
         end
         ST_FOUND: begin
            start_in    = run_start;
            end_in      = run_end;
            mk_rd_in    = run_start[BW-1:WORD_LOG];
            mk_issue_in = 1'b1;
            state_in    = ST_MARK;
         end
         ST_MARK: begin
            pend_in      = mk_issue_ff;
            pend_word_in = mk_rd_ff;
            if (mk_issue_ff) begin
               if (mk_rd_ff == end_word) begin
                  mk_issue_in = 1'b0;
               end else begin
                  mk_rd_in = mk_rd_ff + WIW'(1);
               end
            end
            if (pend_ff && (pend_word_ff == end_word)) begin
               alloc_in      = alloc_sum;
               rsp_valid_in  = 1'b1;
               rsp_status_in = cea_pkg::STATUS_OK;
               rsp_start_in  = cea_pkg::START_W'(start_ff);
               rsp_free_in   = cea_pkg::COUNT_W'(free_new);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         alloc_ff     <= '0;
         csr_ff       <= cea_pkg::CFG_RESET;
         clr_ff       <= '0;
         sc_issue_ff  <= 1'b0;
         dv_ff        <= 1'b0;
         mk_issue_ff  <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff     <= alloc_in;
         csr_ff       <= csr_in;
         clr_ff       <= clr_in;
         sc_issue_ff  <= sc_issue_in;
         dv_ff        <= dv_in;
         mk_issue_ff  <= mk_issue_in;
         pend_ff      <= pend_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
      len_ff        <= len_in;
      rem_ff        <= rem_in;
      rd_word_ff    <= rd_word_in;
      proc_word_ff  <= proc_word_in;
      hit_word_ff   <= hit_word_in;
      hit_j_ff      <= hit_j_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      mk_rd_ff      <= mk_rd_in;
      pend_word_ff  <= pend_word_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_first_block = rsp_start_ff;
   assign rsp_free_blocks = rsp_free_ff;

`ifndef NO_ASSERTIONS
   a_zero_len_nospace: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_run_length == '0)) |=>
         (rsp_valid && (rsp_status == cea_pkg::STATUS_NOSPACE)))
      else $error("zero length request not answered with no-space");

   a_rsp_frees_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while block still busy");

   a_ok_after_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cea_pkg::STATUS_OK)) |-> $past(state_ff == ST_MARK))
      else $error("ok result without a marking pass");

   a_scan_in_limit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && dv_ff) |-> (proc_word_ff <= last_word))
      else $error("scan evaluated a word past the limit");

   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MARK) && pend_ff) |->
         ((pend_word_ff >= start_word) && (pend_word_ff <= end_word)))
      else $error("map write outside the allocated run");
`endif

endmodule

`default_nettype wire
